>>> sv/hte_pkg.sv
// shared types, codes and helpers for the huffman table encoder and packer
`default_nettype none

package hte_pkg;

  // fixed field widths
  localparam int KIND_W = 2;
  localparam int SYM_BITS = 8;
  localparam int LEN_W = 7;
  localparam int CODE_W = 64;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // request kinds on the input channel
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  // work items handed from front to back
  typedef enum logic {
    OP_DATA,
    OP_FLUSH
  } hte_op_t;

  typedef struct packed {
    hte_op_t           op;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] val;
  } hte_entry_t;

  // one table row
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] val;
  } hte_row_t;

  // ones in the low n bits, all ones for n of 64 and more
  function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] n);
    logic [CODE_W-1:0] m;
    if (n >= LEN_W'(CODE_W)) begin
      m = '1;
    end else begin
      m = (CODE_W'(1) << n) - CODE_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> sv/hte_in_if.sv
// input channel: valid, ready and one request's fields
`default_nettype none

interface hte_in_if;
  logic                          valid;
  logic                          ready;
  logic [hte_pkg::KIND_W-1:0]    kind;
  logic [hte_pkg::SYM_BITS-1:0]  symbol;
  logic [hte_pkg::LEN_W-1:0]     code_length;
  logic [hte_pkg::CODE_W-1:0]    code_bits;

  modport source (output valid, kind, symbol, code_length, code_bits, input ready);
  modport sink (input valid, kind, symbol, code_length, code_bits, output ready);
endinterface

`default_nettype wire

>>> sv/hte_out_if.sv
// result channel: valid, ready and one packed word
`default_nettype none

interface hte_out_if;
  logic                       valid;
  logic                       ready;
  logic [hte_pkg::CODE_W-1:0] packed_word;
  logic [hte_pkg::LEN_W-1:0]  bit_count;
  logic                       final_word;

  modport source (output valid, packed_word, bit_count, final_word, input ready);
  modport sink (input valid, packed_word, bit_count, final_word, output ready);
endinterface

`default_nettype wire

>>> sv/hte_front.sv
// front end: code table, request classification and one lookup stage
`default_nettype none

module hte_front #(
  parameter int SYMBOL_COUNT = 256,
  parameter int WORD_BITS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [hte_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [hte_pkg::SYM_BITS-1:0]  in_symbol,
  input  wire logic [hte_pkg::LEN_W-1:0]     in_code_length,
  input  wire logic [hte_pkg::CODE_W-1:0]    in_code_bits,
  input  wire logic                          q_full,
  output logic                               q_push,
  output hte_pkg::hte_entry_t                q_ent
);
  import hte_pkg::*;

  localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  hte_row_t              tbl_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] written_r;
  hte_row_t              rd_r;
  logic                  hit_r;
  logic                  s1_valid_r;
  hte_op_t               s1_op_r;

  logic                  accept;
  logic                  sym_ok;
  logic [SYM_W-1:0]      idx;
  logic                  do_load;
  logic                  do_data;
  logic                  do_flush;
  logic [LEN_W-1:0]      len_sat;

  // classify the request
  assign accept   = in_valid && in_ready;
  assign sym_ok   = ({1'b0, in_symbol} < (SYM_BITS + 1)'(SYMBOL_COUNT));
  assign idx      = in_symbol[SYM_W-1:0];
  assign do_load  = accept && (in_kind == KIND_LOAD) && sym_ok;
  assign do_data  = accept && (in_kind == KIND_DATA) && sym_ok;
  assign do_flush = accept && (in_kind == KIND_FLUSH);
  assign len_sat  = (in_code_length > LEN_W'(WORD_BITS)) ? LEN_W'(WORD_BITS) : in_code_length;

  // lookup stage moves on whenever the queue has room
  assign in_ready = !s1_valid_r || !q_full;
  assign q_push   = s1_valid_r && !q_full;

  always_comb begin
    q_ent.op  = s1_op_r;
    q_ent.len = hit_r ? rd_r.len : '0;
    q_ent.val = rd_r.val;
  end

  // code table: write on load, registered read on data byte
  always_ff @(posedge clk) begin
    if (do_load) begin
      tbl_mem[idx] <= '{len: len_sat, val: in_code_bits & low_mask(len_sat)};
    end
    if (do_data) begin
      rd_r <= tbl_mem[idx];
    end
  end

  // written flags stand in for the all-zero length reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      hit_r     <= 1'b0;
    end else begin
      if (do_load) begin
        written_r[idx] <= 1'b1;
      end
      if (do_data) begin
        hit_r <= written_r[idx];
      end
    end
  end

  // lookup stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_op_r    <= OP_DATA;
    end else begin
      if (do_data || do_flush) begin
        s1_valid_r <= 1'b1;
        s1_op_r    <= do_flush ? OP_FLUSH : OP_DATA;
      end else if (q_push) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/hte_queue.sv
// short queue of work items between front and back
`default_nettype none

module hte_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire hte_pkg::hte_entry_t  push_ent,
  output logic                      full,
  output logic                      pop_valid,
  output hte_pkg::hte_entry_t       pop_ent,
  input  wire logic                 pop
);
  import hte_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hte_entry_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_ent   = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_ent;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/hte_back.sv
// back end: bit accumulator, word packing and output register
`default_nettype none

module hte_back #(
  parameter int WORD_BITS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_valid,
  input  wire hte_pkg::hte_entry_t       q_ent,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [hte_pkg::CODE_W-1:0]     out_packed_word,
  output logic [hte_pkg::LEN_W-1:0]      out_bit_count,
  output logic                           out_final_word
);
  import hte_pkg::*;

  localparam int HELD_W = $clog2(WORD_BITS);

  logic [CODE_W-1:0] acc_r, acc_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic              ov_r, ov_nxt;
  logic [CODE_W-1:0] ow_r, ow_nxt;
  logic [LEN_W-1:0]  oc_r, oc_nxt;
  logic              of_r, of_nxt;
  logic [LEN_W-1:0]  total;
  logic [LEN_W-1:0]  over;

  // take an item when the output register is free or draining
  assign q_pop = q_valid && (!ov_r || out_ready);

  assign total = LEN_W'(held_r) + q_ent.len;
  assign over  = total - LEN_W'(WORD_BITS);

  // pack one code or flush the tail
  always_comb begin
    acc_nxt  = acc_r;
    held_nxt = held_r;
    ov_nxt   = ov_r && !out_ready;
    ow_nxt   = ow_r;
    oc_nxt   = oc_r;
    of_nxt   = of_r;
    if (q_pop) begin
      case (q_ent.op)
        OP_DATA: begin
          if (q_ent.len != '0) begin
            if (total < LEN_W'(WORD_BITS)) begin
              acc_nxt  = ((acc_r << q_ent.len) | q_ent.val) & low_mask(total);
              held_nxt = HELD_W'(total);
            end else begin
              ow_nxt   = ((acc_r << (q_ent.len - over)) | (q_ent.val >> over))
                         & low_mask(LEN_W'(WORD_BITS));
              oc_nxt   = LEN_W'(WORD_BITS);
              of_nxt   = 1'b0;
              ov_nxt   = 1'b1;
              acc_nxt  = q_ent.val & low_mask(over);
              held_nxt = HELD_W'(over);
            end
          end
        end
        OP_FLUSH: begin
          if (held_r != '0) begin
            ow_nxt   = acc_r;
            oc_nxt   = LEN_W'(held_r);
            of_nxt   = 1'b1;
            ov_nxt   = 1'b1;
            acc_nxt  = '0;
            held_nxt = '0;
          end
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
  end

  // accumulator and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ow_r <= ow_nxt;
    oc_r <= oc_nxt;
    of_r <= of_nxt;
  end

  assign out_valid       = ov_r;
  assign out_packed_word = ow_r;
  assign out_bit_count   = oc_r;
  assign out_final_word  = of_r;

endmodule

`default_nettype wire

>>> sv/huffman_table_encoder_packer_core.sv
// top level of the huffman encoder with code table and word packer
//
//  channel   dir  handshake          payload
//  in_chan   in   valid / ready      kind, symbol, code_length, code_bits
//  out_chan  out  valid / ready      packed_word, bit_count, final_word
//
// one request per cycle sustained unless a full queue holds the lookup stage; a table
// load, data byte or flush each take one slot; a data byte passes the registered table
// read, then a queue slot, then the packer before its word shows in the output register
// reset is synchronous; the per-symbol written flags clear at once, no clearing pass
// the two-entry queue lets the lookup keep going while the output waits on out_chan.ready
`default_nettype none

module huffman_table_encoder_packer_core #(
  parameter int SYMBOL_COUNT = 256,
  parameter int WORD_BITS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hte_in_if.sink     in_chan,
  hte_out_if.source  out_chan
);
  import hte_pkg::*;

  logic       q_full;
  logic       q_push;
  hte_entry_t push_ent;
  logic       q_valid;
  hte_entry_t pop_ent;
  logic       q_pop;

  hte_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_chan.valid),
    .in_ready(in_chan.ready),
    .in_kind(in_chan.kind),
    .in_symbol(in_chan.symbol),
    .in_code_length(in_chan.code_length),
    .in_code_bits(in_chan.code_bits),
    .q_full(q_full),
    .q_push(q_push),
    .q_ent(push_ent)
  );

  hte_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_ent(push_ent),
    .full(q_full),
    .pop_valid(q_valid),
    .pop_ent(pop_ent),
    .pop(q_pop)
  );

  hte_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_ent(pop_ent),
    .q_pop(q_pop),
    .out_valid(out_chan.valid),
    .out_ready(out_chan.ready),
    .out_packed_word(out_chan.packed_word),
    .out_bit_count(out_chan.bit_count),
    .out_final_word(out_chan.final_word)
  );

endmodule

`default_nettype wire

>>> bench/huffman_table_encoder_packer_core_tb.sv
// testbench for the huffman table encoder and word packer: predicted words against the block
`timescale 1ns / 1ps

module huffman_table_encoder_packer_core_tb;
  import hte_pkg::*;

  localparam int SYMBOL_SLOTS = 256;
  localparam int RANDOM_REQUESTS = 700;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;

  // the request kind the block must ignore
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [CODE_W-1:0] packed_word;
    logic [LEN_W-1:0]  bit_count;
    logic              final_word;
  } packed_result_t;

  // code table, bit accumulator and the words still owed by the block
  class packed_word_board;
    logic [LEN_W-1:0]  length_table [SYMBOL_SLOTS];
    logic [CODE_W-1:0] value_table [SYMBOL_SLOTS];
    logic [CODE_W-1:0] held_bits;
    int unsigned       held_count;
    packed_result_t    pending_words [$];
    int unsigned       mismatches;
    int unsigned       words_seen;
    int unsigned       tails_seen;

    function new();
      foreach (length_table[i]) begin
        length_table[i] = '0;
        value_table[i] = '0;
      end
      held_bits = '0;
      held_count = 0;
      mismatches = 0;
      words_seen = 0;
      tails_seen = 0;
    endfunction

    function logic [CODE_W-1:0] ones_below(int unsigned n);
      if (n >= CODE_W) return '1;
      return (CODE_W'(1) << n) - CODE_W'(1);
    endfunction

    // update the table or accumulator for one accepted request
    function void note_request(logic [KIND_W-1:0] kind, logic [SYM_BITS-1:0] sym,
                               logic [LEN_W-1:0] len, logic [CODE_W-1:0] bits);
      int unsigned       clen;
      int unsigned       total;
      int unsigned       over;
      logic [CODE_W-1:0] cval;
      packed_result_t    word;
      case (kind)
        KIND_LOAD: begin
          // long lengths saturate, value bits above the length drop
          clen = len;
          if (clen > CODE_W) clen = CODE_W;
          length_table[sym] = LEN_W'(clen);
          value_table[sym] = bits & ones_below(clen);
        end
        KIND_DATA: begin
          clen = length_table[sym];
          if (clen != 0) begin
            cval = value_table[sym];
            total = held_count + clen;
            if (total < CODE_W) begin
              held_bits = ((held_bits << clen) | cval) & ones_below(total);
              held_count = total;
            end else begin
              // word completes, the spill stays in the accumulator
              over = total - CODE_W;
              word.packed_word = (held_bits << (clen - over)) | (cval >> over);
              word.bit_count = LEN_W'(CODE_W);
              word.final_word = 1'b0;
              pending_words.push_back(word);
              held_bits = cval & ones_below(over);
              held_count = over;
            end
          end
        end
        KIND_FLUSH: begin
          // tail only when bits are held
          if (held_count != 0) begin
            word.packed_word = held_bits & ones_below(held_count);
            word.bit_count = LEN_W'(held_count);
            word.final_word = 1'b1;
            pending_words.push_back(word);
          end
          held_bits = '0;
          held_count = 0;
        end
        default: ;
      endcase
    endfunction

    // compare one accepted word with the oldest owed one
    function void check_word(logic [CODE_W-1:0] word, logic [LEN_W-1:0] count, logic fin);
      packed_result_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected word %h bit_count %0d final_word %0b", word, count, fin);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      if (want.final_word) tails_seen++;
      else words_seen++;
      if (word !== want.packed_word) begin
        $error("packed_word expected %h actual %h", want.packed_word, word);
        mismatches++;
      end
      if (count !== want.bit_count) begin
        $error("bit_count expected %0d actual %0d", want.bit_count, count);
        mismatches++;
      end
      if (fin !== want.final_word) begin
        $error("final_word expected %0b actual %0b", want.final_word, fin);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hte_in_if  in_chan ();
  hte_out_if out_chan ();

  huffman_table_encoder_packer_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  packed_word_board board;
  int unsigned      cycle_count = 0;
  int unsigned      sent_loads = 0;
  int unsigned      sent_bytes = 0;
  int unsigned      sent_flushes = 0;
  int unsigned      sent_spare = 0;
  int unsigned      words_taken = 0;
  bit               send_steady = 1'b0;
  bit               take_steady = 1'b0;

  // clock
  always #4 clk = ~clk;

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[huffman_table_encoder_packer_core] ERROR");
      $finish;
    end
  end

  function automatic logic [CODE_W-1:0] rand_code_bits();
    return {$urandom, $urandom};
  endfunction

  // mostly short codes, some long, a few cleared or oversized
  function automatic logic [LEN_W-1:0] rand_code_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 70) return LEN_W'($urandom_range(1, 12));
    if (r < 88) return LEN_W'($urandom_range(13, 40));
    if (r < 96) return LEN_W'($urandom_range(41, 64));
    return LEN_W'($urandom_range(65, 127));
  endfunction

  // present one request, hold it until accepted
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SYM_BITS-1:0] sym,
                              input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind <= kind;
    in_chan.symbol <= sym;
    in_chan.code_length <= len;
    in_chan.code_bits <= bits;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_request(kind, sym, len, bits);
    case (kind)
      KIND_LOAD:  sent_loads++;
      KIND_DATA:  sent_bytes++;
      KIND_FLUSH: sent_flushes++;
      default:    sent_spare++;
    endcase
  endtask

  // hold off new requests until every owed word has come out
  task automatic drain_pause();
    in_chan.valid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, check every accepted word
  task automatic take_words();
    int unsigned stall;
    forever begin
      stall = take_steady ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      board.check_word(out_chan.packed_word, out_chan.bit_count, out_chan.final_word);
      words_taken++;
      if (words_taken % 40 == 0) take_steady = ($urandom_range(0, 2) == 0);
    end
  endtask

  // edge cases of the packer and the table
  task automatic run_directed();
    // flush with nothing held, unused symbol, ignored kind
    send_request(KIND_FLUSH, 8'd0, 7'd0, '0);
    send_request(KIND_DATA, 8'd0, 7'd0, '0);
    send_request(KIND_SPARE, 8'hFF, 7'h7F, '1);
    // loads: value bits above length, full length, saturated lengths
    send_request(KIND_LOAD, 8'd0, 7'd1, '1);
    send_request(KIND_LOAD, 8'hFF, 7'd64, 64'hA5A5_0F0F_3C3C_9696);
    send_request(KIND_LOAD, 8'd1, 7'd127, 64'hFEDC_BA98_7654_3210);
    send_request(KIND_LOAD, 8'd2, 7'd65, 64'h0123_4567_89AB_CDEF);
    send_request(KIND_LOAD, 8'd3, 7'd63, '1);
    send_request(KIND_LOAD, 8'h80, 7'd5, '0);
    // exactly one word, then a full-length code with nothing held
    send_request(KIND_DATA, 8'd0, 7'd0, '0);
    send_request(KIND_DATA, 8'd3, 7'd0, '0);
    send_request(KIND_DATA, 8'hFF, 7'h7F, '1);
    // one bit spills past the word
    send_request(KIND_DATA, 8'd0, 7'd0, '0);
    send_request(KIND_DATA, 8'hFF, 7'd0, '0);
    send_request(KIND_DATA, 8'd1, 7'd0, '0);
    send_request(KIND_DATA, 8'd2, 7'd0, '0);
    // one-bit tail, then a second flush with nothing held
    send_request(KIND_FLUSH, 8'hFF, 7'h7F, '1);
    send_request(KIND_FLUSH, 8'd0, 7'd0, '0);
    // cleared entry goes back to unused
    send_request(KIND_LOAD, 8'd0, 7'd0, '1);
    send_request(KIND_DATA, 8'd0, 7'd0, '0);
    // zero-valued code across a word, ignored kind carrying a data byte
    send_request(KIND_DATA, 8'd3, 7'd0, '0);
    send_request(KIND_DATA, 8'h80, 7'd0, '0);
    send_request(KIND_SPARE, 8'd3, 7'd1, 64'd1);
    send_request(KIND_FLUSH, 8'd0, 7'd0, '0);
  endtask

  // one load burst followed by a byte stream with noise mixed in
  task automatic run_phase();
    logic [SYM_BITS-1:0] live_syms [$];
    logic [SYM_BITS-1:0] sym;
    int unsigned         n_loads;
    int unsigned         n_bytes;
    int unsigned         r;
    n_loads = $urandom_range(2, 12);
    for (int i = 0; i < n_loads; i++) begin
      sym = SYM_BITS'($urandom_range(0, SYMBOL_SLOTS - 1));
      live_syms.push_back(sym);
      send_request(KIND_LOAD, sym, rand_code_length(), rand_code_bits());
    end
    n_bytes = $urandom_range(10, 60);
    for (int i = 0; i < n_bytes; i++) begin
      r = $urandom_range(0, 99);
      sym = live_syms[$urandom_range(0, live_syms.size() - 1)];
      if (r < 80) begin
        send_request(KIND_DATA, sym, LEN_W'($urandom), rand_code_bits());
      end else if (r < 88) begin
        send_request(KIND_DATA, SYM_BITS'($urandom), LEN_W'($urandom), rand_code_bits());
      end else if (r < 93) begin
        send_request(KIND_LOAD, sym, rand_code_length(), rand_code_bits());
      end else if (r < 97) begin
        send_request(KIND_FLUSH, SYM_BITS'($urandom), LEN_W'($urandom), rand_code_bits());
      end else begin
        send_request(KIND_SPARE, SYM_BITS'($urandom), LEN_W'($urandom), rand_code_bits());
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      send_request(KIND_FLUSH, SYM_BITS'($urandom), LEN_W'($urandom), rand_code_bits());
    end
  endtask

  // reset, stimulus, final verdict
  initial begin : main_seq
    int unsigned phases;
    board = new();
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.kind = KIND_LOAD;
    in_chan.symbol = '0;
    in_chan.code_length = '0;
    in_chan.code_bits = '0;
    out_chan.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    fork
      take_words();
    join_none

    run_directed();
    drain_pause();

    phases = 0;
    while (sent_loads + sent_bytes + sent_flushes < RANDOM_REQUESTS + 25) begin
      send_steady = ($urandom_range(0, 3) == 0);
      run_phase();
      phases++;
      if (phases % 5 == 0) drain_pause();
    end
    drain_pause();

    $display("run covered %0d loads, %0d data bytes, %0d flushes, %0d ignored requests",
             sent_loads, sent_bytes, sent_flushes, sent_spare);
    $display("checked %0d full words and %0d flushed tails over %0d phases",
             board.words_seen, board.tails_seen, phases);
    if (board.mismatches == 0 && board.pending_words.size() == 0) begin
      $display("[huffman_table_encoder_packer_core] OK");
    end else begin
      $display("[huffman_table_encoder_packer_core] ERROR");
    end
    $finish;
  end

endmodule
